// ===== src/smna_pkg.sv =====
// Shared types and constants for the scalar mod-n ALU.
package smna_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned NumW  = 256;

  localparam logic [NumW-1:0] OrderN =
    256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEBAAEDCE6AF48A03BBFD25E8CD0364141;
  localparam logic [NumW-1:0] OrderNm2 =
    256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEBAAEDCE6AF48A03BBFD25E8CD036413F;

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [NumW-1:0] a;
    logic [NumW-1:0] b;
  } job_t;

  typedef struct packed {
    logic [NumW-1:0] c;
    logic            no_inv;
  } res_t;

  function automatic logic [NumW-1:0] reduce_once(input logic [NumW-1:0] x);
    reduce_once = (x >= OrderN) ? x - OrderN : x;
  endfunction

endpackage

// ===== src/scalar_mod_n_alu_unit.sv =====
// Top level of the scalar mod-n ALU.
// Add and subtract are done directly; multiply is bit-serial over the bits of
// b; divide squares for each exponent bit of n-2 and multiplies by b for each
// set bit (Fermat inversion), then multiplies the inverse by a.
// Result words leave one per pop; the next operand can load meanwhile.
// Asynchronous active-low reset clears all control state.
module scalar_mod_n_alu_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 func_i,
  input  logic [smna_pkg::WordW-1:0] a_word_i,
  input  logic [smna_pkg::WordW-1:0] b_word_i,
  input  logic                       last_word_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [smna_pkg::WordW-1:0] result_word_o,
  output logic                       last_result_o,
  output logic                       no_inverse_o
);

  smna_pkg::job_t job;
  smna_pkg::res_t res;
  logic job_valid, job_ready, res_valid, res_ready;

  smna_front u_front (
    .clk_i, .rst_ni, .push, .full, .func_i, .a_word_i, .b_word_i, .last_word_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  smna_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .res_valid_o(res_valid), .res_ready_i(res_ready), .res_o(res)
  );

  smna_out u_out (
    .clk_i, .rst_ni, .res_valid_i(res_valid), .res_ready_o(res_ready), .res_i(res),
    .empty, .pop, .result_word_o, .last_result_o, .no_inverse_o
  );

endmodule

// ===== src/smna_front.sv =====
// Front end: gathers operand words, reduces operands and hands off a job.
module smna_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic [1:0]               func_i,
  input  logic [smna_pkg::WordW-1:0] a_word_i,
  input  logic [smna_pkg::WordW-1:0] b_word_i,
  input  logic                     last_word_i,
  output logic                     job_valid_o,
  input  logic                     job_ready_i,
  output smna_pkg::job_t           job_o
);

  logic [3:0][smna_pkg::WordW-1:0] a_store_q, b_store_q;
  logic [1:0]                      idx_q;
  logic                            pend_q;
  smna_pkg::op_e                   op_q;
  logic                            acc;

  assign full        = pend_q;
  assign acc         = push && !pend_q;
  assign job_valid_o = pend_q;
  assign job_o.op    = op_q;
  assign job_o.a     = smna_pkg::reduce_once(a_store_q);
  assign job_o.b     = smna_pkg::reduce_once(b_store_q);

  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_store_q[idx_q] <= a_word_i;
      b_store_q[idx_q] <= b_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      pend_q <= 1'b0;
      op_q   <= smna_pkg::OpAdd;
    end else begin
      if (pend_q && job_ready_i) pend_q <= 1'b0;
      if (acc) begin
        op_q <= smna_pkg::op_e'(func_i);
        if (last_word_i) begin
          idx_q  <= '0;
          pend_q <= 1'b1;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

endmodule

// ===== src/smna_back.sv =====
// Back end: bit-serial modular multiply, Fermat inversion and add/sub.
module smna_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  smna_pkg::job_t job_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output smna_pkg::res_t res_o
);

  typedef enum logic [2:0] {
    StIdle, StAddSub, StInvSq, StInvMx, StMul, StDone
  } state_e;

  localparam int unsigned N = smna_pkg::NumW;

  state_e           state_q;
  smna_pkg::op_e    op_q;
  logic [N-1:0]     a_q, b_q, x_q, y_q, acc_q, inv_q, c_q;
  logic [7:0]       bit_q, ebit_q;
  logic             no_inv_q, ret_q;
  logic [N:0]       dbl, sum;
  logic [N-1:0]     dbl_r, step;
  logic [N:0]       add_ab;
  logic [N-1:0]     add_r;
  logic [N-1:0]     sub_ab;
  logic             bor;

  // one mul bit-step: acc = 2*acc (+x) mod n
  assign dbl   = {acc_q, 1'b0};
  assign dbl_r = (dbl >= {1'b0, smna_pkg::OrderN}) ?
                 N'(dbl - {1'b0, smna_pkg::OrderN}) : dbl[N-1:0];
  assign sum   = {1'b0, dbl_r} + {1'b0, x_q};
  assign step  = !y_q[bit_q] ? dbl_r :
                 ((sum >= {1'b0, smna_pkg::OrderN}) ?
                  N'(sum - {1'b0, smna_pkg::OrderN}) : sum[N-1:0]);

  assign add_ab = {1'b0, a_q} + {1'b0, b_q};
  assign add_r  = (add_ab >= {1'b0, smna_pkg::OrderN}) ?
                  N'(add_ab - {1'b0, smna_pkg::OrderN}) : add_ab[N-1:0];
  assign {bor, sub_ab} = {1'b0, a_q} - {1'b0, b_q};

  assign job_ready_o = (state_q == StIdle);
  assign res_valid_o = (state_q == StDone);
  assign res_o.c      = c_q;
  assign res_o.no_inv = no_inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      op_q     <= smna_pkg::OpAdd;
      no_inv_q <= 1'b0;
      ret_q    <= 1'b0;
      bit_q    <= '0;
      ebit_q   <= '0;
      a_q <= '0; b_q <= '0; x_q <= '0; y_q <= '0;
      acc_q <= '0; inv_q <= '0; c_q <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            op_q     <= job_i.op;
            a_q      <= job_i.a;
            b_q      <= job_i.b;
            no_inv_q <= 1'b0;
            unique case (job_i.op)
              smna_pkg::OpAdd, smna_pkg::OpSub: state_q <= StAddSub;
              smna_pkg::OpMul: begin
                x_q <= job_i.a; y_q <= job_i.b; acc_q <= '0;
                bit_q <= 8'd255; ret_q <= 1'b0; state_q <= StMul;
              end
              default: begin
                if (job_i.b == '0) begin
                  no_inv_q <= 1'b1;
                  c_q      <= '0;
                  state_q  <= StDone;
                end else begin
                  inv_q  <= N'(1);
                  ebit_q <= 8'd255;
                  state_q <= StInvSq;
                end
              end
            endcase
          end
        end
        StAddSub: begin
          if (op_q == smna_pkg::OpSub) begin
            c_q <= bor ? sub_ab + smna_pkg::OrderN : sub_ab;
          end else begin
            c_q <= add_r;
          end
          state_q <= StDone;
        end
        StInvSq: begin
          x_q <= inv_q; y_q <= inv_q; acc_q <= '0;
          bit_q <= 8'd255; ret_q <= 1'b1; state_q <= StMul;
        end
        StInvMx: begin
          if (smna_pkg::OrderNm2[ebit_q]) begin
            x_q <= b_q; y_q <= inv_q; acc_q <= '0;
            bit_q <= 8'd255; ret_q <= 1'b0; state_q <= StMul;
          end else if (ebit_q == 8'd0) begin
            x_q <= a_q; y_q <= inv_q; acc_q <= '0;
            bit_q <= 8'd255; op_q <= smna_pkg::OpMul; state_q <= StMul;
          end else begin
            ebit_q <= ebit_q - 8'd1;
            state_q <= StInvSq;
          end
        end
        StMul: begin
          if (bit_q != 8'd0) begin
            acc_q <= step;
            bit_q <= bit_q - 8'd1;
          end else if (op_q == smna_pkg::OpMul) begin
            c_q <= step; state_q <= StDone;
          end else begin
            inv_q <= step;
            if (ret_q) begin
              ret_q <= 1'b0;
              state_q <= StInvMx;
            end else if (ebit_q == 8'd0) begin
              x_q <= a_q; y_q <= step; acc_q <= '0;
              bit_q <= 8'd255; op_q <= smna_pkg::OpMul;
            end else begin
              ebit_q <= ebit_q - 8'd1;
              state_q <= StInvSq;
            end
          end
        end
        StDone: begin
          if (res_ready_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== src/smna_out.sv =====
// Output stage: serializes a 256-bit result into four words.
module smna_out (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       res_valid_i,
  output logic                       res_ready_o,
  input  smna_pkg::res_t             res_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [smna_pkg::WordW-1:0] result_word_o,
  output logic                       last_result_o,
  output logic                       no_inverse_o
);

  logic [smna_pkg::NumW-1:0] c_q;
  logic                      flag_q, busy_q;
  logic [1:0]                k_q;

  assign res_ready_o   = !busy_q;
  assign empty         = !busy_q;
  assign result_word_o = c_q[k_q*smna_pkg::WordW +: smna_pkg::WordW];
  assign last_result_o = (k_q == 2'd3);
  assign no_inverse_o  = flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
      flag_q <= 1'b0;
      c_q    <= '0;
    end else if (!busy_q) begin
      if (res_valid_i) begin
        busy_q <= 1'b1;
        k_q    <= '0;
        c_q    <= res_i.c;
        flag_q <= res_i.no_inv;
      end
    end else if (pop) begin
      k_q <= k_q + 2'd1;
      if (k_q == 2'd3) busy_q <= 1'b0;
    end
  end

endmodule

// ===== src/smna_checker.sv =====
// Port-level checker for the scalar mod-n ALU.
module smna_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       empty,
  input logic                       pop,
  input logic [smna_pkg::WordW-1:0] result_word_o,
  input logic                       last_result_o,
  input logic                       no_inverse_o
);

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(result_word_o))
    else $error("result changed while stalled");

  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && no_inverse_o |-> result_word_o == '0)
    else $error("no_inverse with nonzero word");

  a_flag_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop && !last_result_o |=> !empty && $stable(no_inverse_o))
    else $error("flag changed inside result");

endmodule

bind scalar_mod_n_alu_unit smna_checker u_smna_checker (
  .clk_i, .rst_ni, .empty, .pop, .result_word_o, .last_result_o, .no_inverse_o
);
